@@ src/rc_car_drive_and_light_controller_defines.svh @@
// Assertion macros for the controller files.
// Each macro assumes a clock named clk and a reset named rst in scope.
`ifndef RC_CAR_DRIVE_AND_LIGHT_CONTROLLER_DEFINES_SVH
`define RC_CAR_DRIVE_AND_LIGHT_CONTROLLER_DEFINES_SVH

`ifndef SYNTHESIS

// Checks that a condition holds at every clock edge outside reset.
`define RCC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a trigger is followed in the next cycle by a consequence.
`define RCC_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`else

`define RCC_ASSERT(lbl, prop, msg)
`define RCC_ASSERT_NEXT(lbl, trig, cons, msg)

`endif

`endif

@@ src/rcc_pkg.sv @@
package rcc_pkg;

  // Register index and write data widths of the configuration port.
  localparam int REG_IDX_W = 3;
  localparam int WR_DATA_W = 10;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_STEER_MIN         = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_STEER_MAX         = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MOTOR_MIN         = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MOTOR_MAX         = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_STOP_BAND         = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLINK_HALF_PERIOD = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CONTROL_PERIOD    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DIM_LEVEL         = 3'd7;

  // Register reset values.
  localparam logic [7:0] RST_STEER_MIN         = 8'd100;
  localparam logic [7:0] RST_STEER_MAX         = 8'd250;
  localparam logic [7:0] RST_MOTOR_MIN         = 8'd133;
  localparam logic [7:0] RST_MOTOR_MAX         = 8'd240;
  localparam logic [7:0] RST_STOP_BAND         = 8'd10;
  localparam logic [9:0] RST_BLINK_HALF_PERIOD = 10'd500;
  localparam logic [7:0] RST_CONTROL_PERIOD    = 8'd20;
  localparam logic [7:0] RST_DIM_LEVEL         = 8'd50;

  // Steering position after reset, the middle of the reset steering range.
  localparam logic [7:0] STEER_RESET = 8'd175;

  // Lamp and horn levels.
  localparam logic [7:0] FULL_ON = 8'd255;
  localparam logic [7:0] HORN_ON = 8'd128;
  localparam logic [7:0] LEVEL_OFF = 8'd0;

  // Reciprocal of the slew divisor 40, scaled by 2^13.
  localparam logic [15:0] SLEW_RECIP = 16'd205;

  typedef struct packed {
    logic [7:0] steer_min;
    logic [7:0] steer_max;
    logic [7:0] motor_min;
    logic [7:0] motor_max;
    logic [7:0] stop_band;
    logic [9:0] blink_half_period;
    logic [7:0] control_period;
    logic [7:0] dim_level;
  } cfg_t;

  typedef struct packed {
    logic signed [7:0] steer_axis;
    logic signed [7:0] throttle_axis;
    logic              headlight_button;
    logic              hazard_button;
    logic              horn_button;
  } in_item_t;

  // A tick that triggers a control update, with the flasher phase it sees.
  typedef struct packed {
    logic signed [7:0] steer_axis;
    logic signed [7:0] throttle_axis;
    logic              headlight_button;
    logic              hazard_button;
    logic              horn_button;
    logic              flash_phase;
  } mid_item_t;

  typedef struct packed {
    logic [7:0] steer_duty;
    logic       steer_changed;
    logic [7:0] left_motor_duty;
    logic [7:0] right_motor_duty;
    logic       speed_changed;
    logic [7:0] head_lamp;
    logic [7:0] tail_lamp;
    logic [7:0] horn_duty;
  } out_item_t;

endpackage

@@ src/rc_car_drive_and_light_controller.sv @@
// Drive and light controller: accepts one tick item per cycle while full is low, gives one result per control update.
// Path: a result passes through the command queue, the stage 1 and stage 2 registers and the result queue.
// Throughput: one command per cycle through the three-stage back pipeline while the result queue has room.
// Reset: synchronous, clears the counters, queues and flasher, sets steering to 175
// and every configuration register to its default value.
`include "rc_car_drive_and_light_controller_defines.svh"

module rc_car_drive_and_light_controller #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  rcc_pkg::in_item_t               item,
  output logic                            empty,
  input  logic                            pop,
  output rcc_pkg::out_item_t              result,
  input  logic                            wr_en,
  input  logic [rcc_pkg::REG_IDX_W-1:0]   wr_index,
  input  logic [rcc_pkg::WR_DATA_W-1:0]   wr_data
);

  import rcc_pkg::*;

  localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

  cfg_t       cfg;
  logic       take;
  logic       mid_push;
  mid_item_t  mid_in;
  mid_item_t  mid_out;
  logic       mid_pop;
  logic       mid_empty;
  logic       mid_full;
  logic [LVL_W-1:0] mid_level;
  logic       out_push;
  out_item_t  out_in;
  logic       out_full;
  logic [LVL_W-1:0] out_level;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.steer_min         <= RST_STEER_MIN;
      cfg.steer_max         <= RST_STEER_MAX;
      cfg.motor_min         <= RST_MOTOR_MIN;
      cfg.motor_max         <= RST_MOTOR_MAX;
      cfg.stop_band         <= RST_STOP_BAND;
      cfg.blink_half_period <= RST_BLINK_HALF_PERIOD;
      cfg.control_period    <= RST_CONTROL_PERIOD;
      cfg.dim_level         <= RST_DIM_LEVEL;
    end else if (wr_en) begin
      case (wr_index)
        REG_STEER_MIN:         cfg.steer_min         <= wr_data[7:0];
        REG_STEER_MAX:         cfg.steer_max         <= wr_data[7:0];
        REG_MOTOR_MIN:         cfg.motor_min         <= wr_data[7:0];
        REG_MOTOR_MAX:         cfg.motor_max         <= wr_data[7:0];
        REG_STOP_BAND:         cfg.stop_band         <= wr_data[7:0];
        REG_BLINK_HALF_PERIOD: cfg.blink_half_period <= wr_data;
        REG_CONTROL_PERIOD:    cfg.control_period    <= wr_data[7:0];
        REG_DIM_LEVEL:         cfg.dim_level         <= wr_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Input side: an item is taken whenever the command queue has room.
  assign full = mid_full;
  assign take = push && !mid_full;

  rcc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .take     (take),
    .item     (item),
    .mid_push (mid_push),
    .mid_item (mid_in)
  );

  rcc_fifo #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (mid_push),
    .wr_data (mid_in),
    .rd_en   (mid_pop),
    .rd_data (mid_out),
    .empty   (mid_empty),
    .full    (mid_full),
    .level   (mid_level)
  );

  rcc_back #(
    .DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .mid_empty (mid_empty),
    .mid_item  (mid_out),
    .mid_pop   (mid_pop),
    .out_level (out_level),
    .out_push  (out_push),
    .out_item  (out_in)
  );

  rcc_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data (out_in),
    .rd_en   (pop),
    .rd_data (result),
    .empty   (empty),
    .full    (out_full),
    .level   (out_level)
  );

  // The back pipeline never pops an empty queue, no queue overflows and a full command queue stays full until popped.
  `RCC_ASSERT(a_mid_no_underflow, !(mid_pop && mid_empty), "command queue popped while empty")
  `RCC_ASSERT(a_mid_no_overflow, !(mid_push && mid_full), "command lost on a full queue")
  `RCC_ASSERT(a_out_no_overflow, !(out_push && out_full), "result lost on a full queue")
  `RCC_ASSERT_NEXT(a_level_bound, mid_level == LVL_W'(QUEUE_DEPTH) && !mid_pop, full, "full queue lost an entry")

endmodule

@@ src/rcc_fifo.sv @@
module rcc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic                       empty,
  output logic                       full,
  output logic [$clog2(DEPTH+1)-1:0] level
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int LVL_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             do_wr;
  logic             do_rd;

  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign empty   = (level == '0);
  assign full    = (level == LVL_W'(DEPTH));
  assign rd_data = mem[rd_ptr];

  // Storage, written at the tail.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        level <= level + 1'b1;
      end else if (do_rd && !do_wr) begin
        level <= level - 1'b1;
      end
    end
  end

endmodule

@@ src/rcc_front.sv @@
module rcc_front (
  input  logic              clk,
  input  logic              rst,
  input  rcc_pkg::cfg_t     cfg,
  input  logic              take,
  input  rcc_pkg::in_item_t item,
  output logic              mid_push,
  output rcc_pkg::mid_item_t mid_item
);

  import rcc_pkg::*;

  logic [9:0] blink_ticks;
  logic [9:0] blink_ticks_next;
  logic       flash_phase;
  logic       flash_phase_next;
  logic [7:0] control_ticks;
  logic [7:0] control_ticks_next;
  logic       blink_fire;
  logic       control_fire;

  // Tick counters: the flasher is handled first so a control update sees the new phase.
  always_comb begin
    blink_fire         = (blink_ticks >= cfg.blink_half_period);
    flash_phase_next   = flash_phase ^ blink_fire;
    blink_ticks_next   = blink_fire ? '0 : blink_ticks + 1'b1;
    control_fire       = (control_ticks >= cfg.control_period);
    control_ticks_next = control_fire ? '0 : control_ticks + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_ticks   <= '0;
      flash_phase   <= 1'b0;
      control_ticks <= '0;
    end else if (take) begin
      blink_ticks   <= blink_ticks_next;
      flash_phase   <= flash_phase_next;
      control_ticks <= control_ticks_next;
    end
  end

  // Only ticks that trigger a control update are passed on.
  assign mid_push = take && control_fire;

  always_comb begin
    mid_item.steer_axis       = item.steer_axis;
    mid_item.throttle_axis    = item.throttle_axis;
    mid_item.headlight_button = item.headlight_button;
    mid_item.hazard_button    = item.hazard_button;
    mid_item.horn_button      = item.horn_button;
    mid_item.flash_phase      = flash_phase_next;
  end

endmodule

@@ src/rcc_back.sv @@
module rcc_back #(
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  rcc_pkg::cfg_t              cfg,
  input  logic                       mid_empty,
  input  rcc_pkg::mid_item_t         mid_item,
  output logic                       mid_pop,
  input  logic [$clog2(DEPTH+1)-1:0] out_level,
  output logic                       out_push,
  output rcc_pkg::out_item_t         out_item
);

  import rcc_pkg::*;

  localparam int LVL_W = $clog2(DEPTH + 1);

  // Truncating division by 255 of a signed product, then offset by the range bottom.
  function automatic logic [7:0] scale_div(input logic signed [17:0] p, input logic [7:0] lo);
    logic [17:0] mag;
    logic [15:0] sum;
    logic [7:0]  q;
    mag = p[17] ? 18'(-p) : p;
    sum = mag[15:0] + {8'd0, mag[15:8]} + 16'd1;
    q   = sum[15:8];
    return lo + (p[17] ? 8'(-q) : q);
  endfunction

  // Stage 1 registers: products of the axis offsets and range spans.
  logic               v1;
  logic signed [17:0] prod_s1;
  logic signed [17:0] prod_t1;
  mid_item_t          item1;

  // Stage 2 registers: mapped steering target and speed.
  logic               v2;
  logic [7:0]         target2;
  logic [7:0]         speed2;
  mid_item_t          item2;

  // State carried from one control update to the next.
  logic [7:0] steer_now;
  logic [7:0] steer_last;
  logic [7:0] speed_last;

  logic [LVL_W+1:0]   credit_sum;
  logic [7:0]         su;
  logic [7:0]         tu;
  logic signed [17:0] su_w;
  logic signed [17:0] tu_w;
  logic signed [17:0] span_s;
  logic signed [17:0] span_t;

  // Pop only when the result queue has room for everything in flight.
  always_comb begin
    credit_sum = (LVL_W + 2)'(out_level) + (LVL_W + 2)'(v1) + (LVL_W + 2)'(v2);
    mid_pop    = !mid_empty && (credit_sum < (LVL_W + 2)'(DEPTH));
  end

  // Stage 1: axis offset by 128 times span.
  always_comb begin
    su     = {~mid_item.steer_axis[7], mid_item.steer_axis[6:0]};
    tu     = {~mid_item.throttle_axis[7], mid_item.throttle_axis[6:0]};
    su_w   = 18'($signed({10'd0, su}));
    tu_w   = 18'($signed({10'd0, tu}));
    span_s = 18'($signed({10'd0, cfg.steer_max})) - 18'($signed({10'd0, cfg.steer_min}));
    span_t = 18'($signed({10'd0, cfg.motor_max})) - 18'($signed({10'd0, cfg.motor_min}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= mid_pop;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      prod_s1 <= su_w * span_s;
      prod_t1 <= tu_w * span_t;
      item1   <= mid_item;
    end
  end

  // Stage 2: divide and offset.
  always_ff @(posedge clk) begin
    if (v1) begin
      target2 <= scale_div(prod_s1, cfg.steer_min);
      speed2  <= scale_div(prod_t1, cfg.motor_min);
      item2   <= item1;
    end
  end

  // Stage 3: steering slew, mirrored motors and lamps.
  logic signed [8:0] diff;
  logic [8:0]        ndiff;
  logic [15:0]       pos_prod;
  logic [15:0]       neg_prod;
  logic [7:0]        step;
  logic [7:0]        cur1;
  logic signed [8:0] diff2;
  logic [7:0]        cur2;
  logic [8:0]        stop_sum;
  logic [7:0]        stop_pt;
  logic signed [8:0] speed_gap;
  logic [8:0]        dist_abs;
  logic              moving;

  always_comb begin
    // Floor of diff / 40 by reciprocal; a negative diff uses -1 - (-diff - 1) / 40.
    diff     = $signed({1'b0, target2}) - $signed({1'b0, steer_now});
    ndiff    = ~diff;
    pos_prod = {8'd0, diff[7:0]} * SLEW_RECIP;
    neg_prod = {8'd0, ndiff[7:0]} * SLEW_RECIP;
    step     = diff[8] ? ~{5'd0, neg_prod[15:13]} : {5'd0, pos_prod[15:13]};
    cur1     = steer_now + step;

    // A further step of at most one toward the target.
    diff2 = $signed({1'b0, target2}) - $signed({1'b0, cur1});
    if (diff2 > 9'sd1) begin
      cur2 = cur1 + 8'd1;
    end else if (diff2 < -9'sd1) begin
      cur2 = cur1 - 8'd1;
    end else begin
      cur2 = target2;
    end

    // Distance of the speed from the stop point.
    stop_sum  = {1'b0, cfg.motor_min} + {1'b0, cfg.motor_max};
    stop_pt   = stop_sum[8:1];
    speed_gap = $signed({1'b0, speed2}) - $signed({1'b0, stop_pt});
    dist_abs  = speed_gap[8] ? 9'(-speed_gap) : speed_gap;
    moving    = (dist_abs > {1'b0, cfg.stop_band});

    out_item.steer_duty       = cur2;
    out_item.steer_changed    = (cur2 != steer_last);
    out_item.left_motor_duty  = speed2;
    out_item.right_motor_duty = cfg.motor_max + cfg.motor_min - speed2;
    out_item.speed_changed    = (speed2 != speed_last);
    if (item2.hazard_button) begin
      out_item.head_lamp = item2.flash_phase ? cfg.dim_level : LEVEL_OFF;
      out_item.tail_lamp = item2.flash_phase ? FULL_ON : LEVEL_OFF;
    end else begin
      out_item.head_lamp = item2.headlight_button ? FULL_ON : LEVEL_OFF;
      if (moving) begin
        out_item.tail_lamp = item2.headlight_button ? cfg.dim_level : LEVEL_OFF;
      end else begin
        out_item.tail_lamp = FULL_ON;
      end
    end
    out_item.horn_duty = item2.horn_button ? HORN_ON : LEVEL_OFF;
  end

  assign out_push = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_now  <= STEER_RESET;
      steer_last <= '0;
      speed_last <= '0;
    end else if (v2) begin
      steer_now  <= cur2;
      steer_last <= cur2;
      speed_last <= speed2;
    end
  end

endmodule
